// ===== design/internet_checksum_accumulator_assert.svh =====
// Assertion macros for the checker file of the checksum accumulator.
`ifndef INTERNET_CHECKSUM_ACCUMULATOR_ASSERT_SVH
`define INTERNET_CHECKSUM_ACCUMULATOR_ASSERT_SVH

// Checked only while reset is released.
`define ICA_ASSERT_RUN(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checked in every cycle, reset included.
`define ICA_ASSERT_ANY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ica_pkg.sv =====
package ica_pkg;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_EMPTY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic        first;
        logic        last;
        logic        start_odd;
        logic [31:0] init_sum;
    } t_item;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_qstat;

endpackage

// ===== design/ica_fifo.sv =====
module ica_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ica_pkg::t_item   i_item,
    input  logic             i_pop,
    output ica_pkg::t_item   o_item,
    output ica_pkg::t_qstat  o_qstat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ica_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wptr, n_wptr;
    logic [AW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_item           = r_mem[r_rptr];
    assign o_qstat.full     = (r_cnt == CW'(DEPTH));
    assign o_qstat.nonempty = (r_cnt != '0);

endmodule

// ===== design/ica_front.sv =====
module ica_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_first,
    input  logic            i_last,
    input  logic            i_start_odd,
    input  logic [31:0]     i_init_sum,
    input  logic            i_empty_req,
    input  ica_pkg::t_qstat i_qstat,
    output logic            o_push,
    output ica_pkg::t_item  o_item
);

    logic           r_vld, n_vld;
    ica_pkg::t_item r_item;
    logic           accept;

    assign o_push  = r_vld && !i_qstat.full;
    assign o_ready = !r_vld || !i_qstat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.kind      <= i_empty_req ? ica_pkg::KIND_EMPTY : ica_pkg::KIND_BYTE;
            r_item.data_byte <= i_data_byte;
            r_item.first     <= i_first;
            r_item.last      <= i_last;
            r_item.start_odd <= i_start_odd;
            r_item.init_sum  <= i_init_sum;
        end
    end

    assign o_item = r_item;

endmodule

// ===== design/ica_back.sv =====
module ica_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ica_pkg::t_qstat i_qstat,
    input  ica_pkg::t_item  i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_checksum
);

    logic [31:0] r_acc;
    logic        r_high_lane;
    logic        r_swap;

    logic        r_fold_vld;
    logic        r_fold_raw;
    logic        r_fold_swap;
    logic [31:0] r_fold_sum;

    logic        r_out_vld;
    logic [31:0] r_out;

    logic        out_free;
    logic        fold_free;
    logic        is_empty;
    logic        produces;
    logic [31:0] base;
    logic        lane;
    logic        swap;
    logic [31:0] addend;
    logic [31:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] swapped;
    logic [31:0] result;

    assign out_free  = !r_out_vld || i_ready;
    assign fold_free = !r_fold_vld || out_free;
    assign is_empty  = (i_item.kind == ica_pkg::KIND_EMPTY);
    assign produces  = is_empty || i_item.last;
    assign o_pop     = i_qstat.nonempty && (!produces || fold_free);

    assign base   = i_item.first ? i_item.init_sum : r_acc;
    assign lane   = i_item.first ? i_item.start_odd : r_high_lane;
    assign swap   = i_item.first ? i_item.start_odd : r_swap;
    assign addend = lane ? {16'b0, i_item.data_byte, 8'b0} : {24'b0, i_item.data_byte};
    assign sum    = base + addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_high_lane <= 1'b0;
            r_swap      <= 1'b0;
        end else if (o_pop && !is_empty) begin
            if (i_item.last) begin
                r_acc       <= '0;
                r_high_lane <= 1'b0;
                r_swap      <= 1'b0;
            end else begin
                r_acc       <= sum;
                r_high_lane <= !lane;
                r_swap      <= swap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (fold_free) begin
                r_fold_vld <= o_pop && produces;
            end
            if (out_free) begin
                r_out_vld <= r_fold_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fold_free) begin
            r_fold_raw  <= is_empty;
            r_fold_swap <= swap;
            r_fold_sum  <= is_empty ? i_item.init_sum : sum;
        end
        if (out_free) begin
            r_out <= result;
        end
    end

    assign fold1   = {1'b0, r_fold_sum[15:0]} + {1'b0, r_fold_sum[31:16]};
    assign fold2   = fold1[15:0] + {15'b0, fold1[16]};
    assign swapped = r_fold_swap ? {fold2[7:0], fold2[15:8]} : fold2;
    assign result  = r_fold_raw ? r_fold_sum : {16'b0, swapped};

    assign o_valid    = r_out_vld;
    assign o_checksum = r_out;

endmodule

// ===== design/internet_checksum_accumulator.sv =====
// Internet checksum accumulator (RFC 1071 style) that takes one buffer byte per
// transaction and returns the folded 16-bit sum, byte-swapped for a buffer that starts at an
// odd address, without the final complement; a zero-length request returns its starting sum
// unchanged. It sustains one byte per clock cycle unless a stalled result blocks the queue, a
// rate set by the single 32-bit add of the running sum in the back end. An input register
// and a short queue separate the intake from the adder, and the fold stage and the output
// register let new bytes enter while a result waits.
module internet_checksum_accumulator #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first,
    input  logic        i_last,
    input  logic        i_start_odd,
    input  logic [31:0] i_init_sum,
    input  logic        i_empty_req,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_checksum
);

    ica_pkg::t_qstat qstat;
    ica_pkg::t_item  push_item;
    ica_pkg::t_item  head_item;
    logic            push;
    logic            pop;

    ica_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_first     (i_first),
        .i_last      (i_last),
        .i_start_odd (i_start_odd),
        .i_init_sum  (i_init_sum),
        .i_empty_req (i_empty_req),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_item      (push_item)
    );

    ica_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_qstat (qstat)
    );

    ica_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (qstat),
        .i_item     (head_item),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_checksum (o_checksum)
    );

endmodule

// ===== design/ica_checker.sv =====
`include "internet_checksum_accumulator_assert.svh"

module ica_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_checksum
);

    // A result transaction that is not taken stays offered with the same value.
    `ICA_ASSERT_RUN(a_out_hold, o_valid && !i_ready, o_valid, "result dropped while stalled")
    `ICA_ASSERT_RUN(a_out_stable, o_valid && !i_ready, $stable(o_checksum), "result changed")

    // After reset the intake is open and no result leaves the pipeline straight after it.
    `ICA_ASSERT_ANY(a_rst_ready, !i_rst_n, o_ready, "input not ready after reset")
    `ICA_ASSERT_ANY(a_rst_quiet, !i_rst_n, !o_valid ##1 !o_valid, "result too soon after reset")

endmodule

bind internet_checksum_accumulator ica_checker u_ica_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_checksum (o_checksum)
);
